/* design/rth_pkg.sv */
package rth_pkg;

  // channel widths
  localparam int unsigned ChanW = 8;
  localparam int unsigned HueW  = 15;

  // hue divider: remainder width is the channel width, quotient covers 0..3840
  localparam int unsigned QuoW  = 12;
  localparam int unsigned NumW  = ChanW + QuoW;

  // hue scale, 1/64 degree per step
  localparam logic [HueW-1:0] HueSixth    = 15'd3840;
  localparam logic [HueW-1:0] HueFull     = 15'd23040;
  localparam logic [HueW-1:0] HueOfsGreen = 15'd7680;
  localparam logic [HueW-1:0] HueOfsBlue  = 15'd15360;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_e;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic [ChanW-1:0] saturation;
    logic [ChanW-1:0] brightness;
  } hsv_t;

  // travels alongside the hue quotient
  typedef struct packed {
    logic    gray;
    logic    neg;
    sector_e sector;
  } hue_side_t;

endpackage

/* design/rth_div.sv */
module rth_div #(
  parameter int unsigned DEN_W  = 8,
  parameter int unsigned QUO_W  = 12,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [DEN_W+QUO_W-1:0]  num_i,
  input  logic [DEN_W-1:0]        den_i,
  input  logic [SIDE_W-1:0]       side_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [QUO_W-1:0]        quo_o,
  output logic [SIDE_W-1:0]       side_o
);

  // restoring division, one quotient bit per stage
  // caller guarantees the quotient fits QUO_W bits (top DEN_W bits of num below den)

  logic [QUO_W-1:0]  valid_q;
  logic [DEN_W-1:0]  rem_q  [QUO_W];
  logic [QUO_W-1:0]  low_q  [QUO_W];
  logic [DEN_W-1:0]  den_q  [QUO_W];
  logic [SIDE_W-1:0] side_q [QUO_W];
  logic [QUO_W:0]    en;

  assign en[QUO_W] = out_ready_i;

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic              src_valid;
    logic [DEN_W-1:0]  src_rem;
    logic [QUO_W-1:0]  src_low;
    logic [DEN_W-1:0]  src_den;
    logic [SIDE_W-1:0] src_side;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [DEN_W-1:0]  rem_d;
    logic [QUO_W-1:0]  low_d;

    if (k == 0) begin : g_first
      assign src_valid = in_valid_i;
      assign src_rem   = num_i[DEN_W+QUO_W-1:QUO_W];
      assign src_low   = num_i[QUO_W-1:0];
      assign src_den   = den_i;
      assign src_side  = side_i;
    end else begin : g_next
      assign src_valid = valid_q[k-1];
      assign src_rem   = rem_q[k-1];
      assign src_low   = low_q[k-1];
      assign src_den   = den_q[k-1];
      assign src_side  = side_q[k-1];
    end

    // a stage moves when it is empty or the next one moves
    assign en[k] = !valid_q[k] || en[k+1];

    always_comb begin
      trial = {src_rem, src_low[QUO_W-1]};
      diff  = trial - {1'b0, src_den};
      ge    = (trial >= {1'b0, src_den});
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      low_d = {src_low[QUO_W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en[k]) begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        rem_q[k]  <= rem_d;
        low_q[k]  <= low_d;
        den_q[k]  <= src_den;
        side_q[k] <= src_side;
      end
    end
  end

  assign in_ready_o  = en[0];
  assign out_valid_o = valid_q[QUO_W-1];
  assign quo_o       = low_q[QUO_W-1];
  assign side_o      = side_q[QUO_W-1];

endmodule

/* design/rgb_to_hsv.sv */
// rgb_to_hsv: converts one 8-bit RGB pixel into hue, saturation and brightness
//
// input channel in_valid_i / in_ready_o carries one pixel per transfer,
// output channel out_valid_o / out_ready_i carries one hsv result per transfer
// hue is in 1/64 degree steps (0..23039), saturation and brightness scale 255 to 1.0
//
// every pixel gives exactly one result, in order
// from input transfer to out_valid_o a pixel passes one prep register
// (max, min, delta, dividends), 12 divider stages (one quotient bit each, set by
// the 12-bit hue quotient), and one output register
// throughput is one pixel per clock while the receiver takes results
//
// reset clears all valid bits; the pipeline is empty and in_ready_o is high
// when the receiver stalls, the result holds in the output register and the
// stages behind it fill up; bubbles still close up, so new pixels are taken
// until every stage holds a pixel; nothing is lost or repeated
module rgb_to_hsv (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  rth_pkg::pixel_t in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output rth_pkg::hsv_t   out_data_o
);

  import rth_pkg::*;

  // ---------------------------------------------------------------- prep stage
  logic [ChanW-1:0] mx, mn, delta, mag;
  logic signed [ChanW:0] diff;
  sector_e          sector;
  logic [NumW-1:0]  hue_num, sat_num;

  always_comb begin
    mx = in_data_i.red;
    mn = in_data_i.red;
    if (in_data_i.green > mx) mx = in_data_i.green;
    if (in_data_i.blue  > mx) mx = in_data_i.blue;
    if (in_data_i.green < mn) mn = in_data_i.green;
    if (in_data_i.blue  < mn) mn = in_data_i.blue;
    delta = mx - mn;

    // first channel holding the max wins ties
    if (mx == in_data_i.red) begin
      sector = SEC_RED;
      diff   = $signed({1'b0, in_data_i.green}) - $signed({1'b0, in_data_i.blue});
    end else if (mx == in_data_i.green) begin
      sector = SEC_GREEN;
      diff   = $signed({1'b0, in_data_i.blue}) - $signed({1'b0, in_data_i.red});
    end else begin
      sector = SEC_BLUE;
      diff   = $signed({1'b0, in_data_i.red}) - $signed({1'b0, in_data_i.green});
    end
    mag = diff[ChanW] ? ChanW'(-diff) : diff[ChanW-1:0];

    // mag * 3840 = mag * 4096 - mag * 256; a negative num rounds up by adding delta - 1
    hue_num = {mag, 12'd0} - {4'd0, mag, 8'd0};
    if (diff[ChanW]) begin
      hue_num = hue_num + {12'd0, delta - 8'd1};
    end

    // delta * 255
    sat_num = {4'd0, delta, 8'd0} - {12'd0, delta};
  end

  logic             pre_valid_q;
  logic [NumW-1:0]  pre_hue_num_q, pre_sat_num_q;
  logic [ChanW-1:0] pre_delta_q, pre_mx_q;
  hue_side_t        pre_side_q;
  hue_side_t        pre_side_d;
  logic             pre_en;
  logic             hue_in_ready, sat_in_ready;

  assign pre_side_d = '{gray: (delta == '0), neg: diff[ChanW], sector: sector};

  assign pre_en     = !pre_valid_q || hue_in_ready;
  assign in_ready_o = pre_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pre_valid_q <= 1'b0;
    end else if (pre_en) begin
      pre_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pre_en) begin
      pre_hue_num_q <= hue_num;
      pre_sat_num_q <= sat_num;
      pre_delta_q   <= delta;
      pre_mx_q      <= mx;
      pre_side_q    <= pre_side_d;
    end
  end

  // ---------------------------------------------------------------- dividers
  // both dividers see the same valid and ready, so they move in lockstep
  logic             hue_out_valid, sat_out_valid;
  logic [QuoW-1:0]  hue_quo, sat_quo;
  hue_side_t        hue_side;
  logic [ChanW-1:0] sat_side;
  logic             out_en;

  rth_div #(
    .DEN_W  (ChanW),
    .QUO_W  (QuoW),
    .SIDE_W ($bits(hue_side_t))
  ) u_hue_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pre_valid_q),
    .in_ready_o  (hue_in_ready),
    .num_i       (pre_hue_num_q),
    .den_i       (pre_delta_q),
    .side_i      (pre_side_q),
    .out_valid_o (hue_out_valid),
    .out_ready_i (out_en),
    .quo_o       (hue_quo),
    .side_o      (hue_side)
  );

  rth_div #(
    .DEN_W  (ChanW),
    .QUO_W  (QuoW),
    .SIDE_W (ChanW)
  ) u_sat_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (pre_valid_q),
    .in_ready_o  (sat_in_ready),
    .num_i       (pre_sat_num_q),
    .den_i       (pre_mx_q),
    .side_i      (pre_mx_q),
    .out_valid_o (sat_out_valid),
    .out_ready_i (out_en),
    .quo_o       (sat_quo),
    .side_o      (sat_side)
  );

  // ---------------------------------------------------------------- output stage
  logic [HueW-1:0] hue_base, hue_quo_ext, hue_val;
  hsv_t            out_d;
  hsv_t            out_q;
  logic            out_valid_q;

  always_comb begin
    case (hue_side.sector)
      SEC_RED:   hue_base = '0;
      SEC_GREEN: hue_base = HueOfsGreen;
      SEC_BLUE:  hue_base = HueOfsBlue;
      default:   hue_base = '0;
    endcase
    hue_quo_ext = {3'd0, hue_quo};

    if (hue_side.gray) begin
      hue_val = '0;
    end else if (!hue_side.neg) begin
      hue_val = hue_base + hue_quo_ext;
    end else if (hue_side.sector == SEC_RED && hue_quo != '0) begin
      // below zero wraps around the full circle
      hue_val = HueFull - hue_quo_ext;
    end else begin
      hue_val = hue_base - hue_quo_ext;
    end

    out_d.hue        = hue_val;
    // black pixel divides by zero; force zero
    out_d.saturation = (sat_side == '0) ? '0 : sat_quo[ChanW-1:0];
    out_d.brightness = sat_side;
  end

  assign out_en = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= hue_out_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------------------------------------------------------- assertions
  // the two dividers must never drift apart
  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hue_out_valid == sat_out_valid) && (hue_in_ready == sat_in_ready))
    else $error("hue and saturation dividers out of step");

  a_hue_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.hue < HueFull))
    else $error("hue out of range");

  a_black_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.brightness == '0) |->
      (out_data_o.saturation == '0 && out_data_o.hue == '0))
    else $error("black pixel with nonzero hue or saturation");

  // an accepted pixel enters the prep register
  a_prep_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> pre_valid_q)
    else $error("accepted pixel lost at prep stage");

endmodule

/* tb/rgb_to_hsv_tb.sv */
`timescale 1ns / 1ps

module rgb_to_hsv_tb;
  import rth_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandPerPass = 342;
  localparam int unsigned DrainCycles = 40;   // well past the full pipeline

  logic   clk_i       = 1'b0;
  logic   rst_ni      = 1'b0;
  logic   in_valid_i  = 1'b0;
  logic   in_ready_o;
  pixel_t in_data_i   = '0;
  logic   out_valid_o;
  logic   out_ready_i = 1'b0;
  hsv_t   out_data_o;

  // directed rows may carry a hand-typed result that rides along with the pixel
  logic   typed_valid = 1'b0;
  hsv_t   typed_hsv   = '0;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;

  hsv_t hsv_pending_q[$];

  typedef struct packed {
    logic   typed;
    pixel_t px;
    hsv_t   hsv;
  } dir_row_t;

  dir_row_t dir_tab[$];

  rgb_to_hsv dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // hue, saturation and brightness of one pixel, exact integer arithmetic
  function automatic hsv_t predict_hsv(pixel_t px);
    int      r, g, b, mx, mn, delta, num, hue_v, sat_v;
    sector_e sec;
    hsv_t    res;
    r  = int'(px.red);
    g  = int'(px.green);
    b  = int'(px.blue);
    mx = r;
    mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    delta = mx - mn;
    sat_v = (mx == 0) ? 0 : (delta * 255) / mx;
    hue_v = 0;
    if (delta != 0) begin
      // first channel equal to the max picks the sector
      if (mx == r) sec = SEC_RED;
      else if (mx == g) sec = SEC_GREEN;
      else sec = SEC_BLUE;
      case (sec)
        SEC_RED:   num = g - b;
        SEC_GREEN: num = b - r;
        default:   num = r - g;
      endcase
      // floored quotient, rounds toward minus infinity
      if (num >= 0) hue_v = (num * int'(HueSixth)) / delta;
      else hue_v = -(((-num) * int'(HueSixth) + delta - 1) / delta);
      case (sec)
        SEC_GREEN: hue_v += int'(HueOfsGreen);
        SEC_BLUE:  hue_v += int'(HueOfsBlue);
        default:   ;
      endcase
      if (hue_v < 0) hue_v += int'(HueFull);
    end
    res.hue        = hue_v[HueW-1:0];
    res.saturation = sat_v[ChanW-1:0];
    res.brightness = mx[ChanW-1:0];
    return res;
  endfunction

  // random pixel, weighted toward ties, grays and channel extremes
  function automatic pixel_t rand_pixel();
    pixel_t      px;
    logic [7:0]  v;
    int unsigned k;
    px = pixel_t'($urandom);
    k  = $urandom_range(9);
    case (k)
      4: begin
        v = 8'($urandom);
        px = '{v, v, v};
      end
      5: begin
        // two channels tied at the max
        v = 8'($urandom_range(255, 1));
        px = '{v, v, 8'($urandom_range(int'(v)))};
        case ($urandom_range(2))
          0: px = '{px.blue, px.red, px.green};
          1: px = '{px.red, px.blue, px.green};
          default: ;
        endcase
      end
      6: begin
        px.red   = $urandom_range(1) ? 8'($urandom_range(255, 254)) : 8'($urandom_range(1));
        px.green = $urandom_range(1) ? 8'($urandom_range(255, 254)) : 8'($urandom_range(1));
        px.blue  = $urandom_range(1) ? 8'($urandom_range(255, 254)) : 8'($urandom_range(1));
      end
      7: begin
        case ($urandom_range(2))
          0: px.red = 8'hff;
          1: px.green = 8'hff;
          default: px.blue = 8'hff;
        endcase
      end
      8: px = '{8'($urandom_range(3)), 8'($urandom_range(3)), 8'($urandom_range(3))};
      9: begin
        // near gray, green and blue each within one step of red
        v = 8'($urandom_range(254, 1));
        px = '{v, v + 8'($urandom_range(1)), v - 8'($urandom_range(1))};
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic add_row(input logic typed, input int r, input int g, input int b,
                         input int h, input int s, input int v);
    dir_row_t row;
    row.typed = typed;
    row.px    = '{r[7:0], g[7:0], b[7:0]};
    row.hsv   = '{h[HueW-1:0], s[7:0], v[7:0]};
    dir_tab.push_back(row);
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_pixel(input pixel_t px, input logic typed, input hsv_t hsv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i  <= 1'b1;
    in_data_i   <= px;
    typed_valid <= typed;
    typed_hsv   <= hsv;
    forever begin
      @(posedge clk_i);
      if (in_ready_o) break;
    end
    @(negedge clk_i);
  endtask

  // hold off the sender until the pipeline has fully drained
  task automatic drain_pipeline();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (hsv_pending_q.size() != 0);
  endtask

  // receiver backpressure, changes on the falling edge like every other input
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // scoreboard: queue on each input transfer, check on each output transfer
  always @(posedge clk_i) begin
    hsv_t exp_hsv;
    if (rst_ni && in_valid_i && in_ready_o) begin
      hsv_pending_q.push_back(typed_valid ? typed_hsv : predict_hsv(in_data_i));
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (hsv_pending_q.size() == 0) begin
        $display("%0t: unexpected result hue %0d sat %0d val %0d", $time,
                 out_data_o.hue, out_data_o.saturation, out_data_o.brightness);
        error_count++;
      end else begin
        exp_hsv = hsv_pending_q.pop_front();
        if (out_data_o.hue !== exp_hsv.hue) begin
          $display("%0t: hue expected %0d actual %0d", $time, exp_hsv.hue, out_data_o.hue);
          error_count++;
        end
        if (out_data_o.saturation !== exp_hsv.saturation) begin
          $display("%0t: saturation expected %0d actual %0d", $time,
                   exp_hsv.saturation, out_data_o.saturation);
          error_count++;
        end
        if (out_data_o.brightness !== exp_hsv.brightness) begin
          $display("%0t: brightness expected %0d actual %0d", $time,
                   exp_hsv.brightness, out_data_o.brightness);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("%0t: timeout, %0d results still pending", $time, hsv_pending_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    // black straight after reset, then grays, primaries, tied maxima
    add_row(1'b1,   0,   0,   0,     0,   0,   0);
    add_row(1'b1, 255, 255, 255,     0,   0, 255);
    add_row(1'b1, 128, 128, 128,     0,   0, 128);
    add_row(1'b1,   1,   1,   1,     0,   0,   1);
    add_row(1'b1, 255,   0,   0,     0, 255, 255);
    add_row(1'b1,   0, 255,   0,  7680, 255, 255);
    add_row(1'b1,   0,   0, 255, 15360, 255, 255);
    add_row(1'b1, 255, 255,   0,  3840, 255, 255);
    add_row(1'b1,   0, 255, 255, 11520, 255, 255);
    add_row(1'b1, 255,   0, 255, 19200, 255, 255);
    // the rest go through the predictor
    add_row(1'b0,   1,   0,   0, 0, 0, 0);
    add_row(1'b0,   0,   1,   0, 0, 0, 0);
    add_row(1'b0,   0,   0,   1, 0, 0, 0);
    add_row(1'b0, 255,   0,   1, 0, 0, 0);
    add_row(1'b0, 255,   1,   0, 0, 0, 0);
    add_row(1'b0, 254, 255, 255, 0, 0, 0);
    add_row(1'b0, 200, 100,  50, 0, 0, 0);
    add_row(1'b0,  10,  20,  30, 0, 0, 0);
    add_row(1'b0,  30,  20,  10, 0, 0, 0);
    add_row(1'b0,   0, 128, 255, 0, 0, 0);
    add_row(1'b0, 255, 254,   0, 0, 0, 0);
    add_row(1'b0,   1,   0,   1, 0, 0, 0);
    add_row(1'b0, 128, 255, 128, 0, 0, 0);
    add_row(1'b0,  17, 255, 254, 0, 0, 0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int pass = 0; pass < 3; pass++) begin
      case (pass)
        0: begin
          send_idle_pct = 26;
          recv_idle_pct = 84;
        end
        1: begin
          send_idle_pct = 84;
          recv_idle_pct = 26;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      if (pass == 0) begin
        foreach (dir_tab[i]) send_pixel(dir_tab[i].px, dir_tab[i].typed, dir_tab[i].hsv);
      end
      for (int n = 0; n < RandPerPass; n++) send_pixel(rand_pixel(), 1'b0, '0);
      drain_pipeline();
    end

    in_valid_i <= 1'b0;
    while (hsv_pending_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
